// File: hdl/spq_pkg.sv
package spq_pkg;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      logic [7:0]         prio;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type item;
   } cmd_type;

endpackage

// File: hdl/spq_cell.sv
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type prev_entry,
   input  logic      prev_go,
   input  entry_type next_entry,
   output entry_type entry,
   output logic      go
);

   entry_type entry_ff;
   entry_type entry_in;

   // go: new item belongs at or before this cell (ties keep older entries ahead)
   assign go = !entry_ff.valid || (entry_ff.prio < cmd.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.push && go) begin
         entry_in = prev_go ? prev_entry : cmd.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.value <= entry_in.value;
      entry_ff.prio  <= entry_in.prio;
   end

   assign entry = entry_ff;

endmodule

// File: hdl/stable_priority_queue_core.sv
// Stable priority queue built as a sorted chain of cells.
// Command channel: a beat is taken at a clock edge where start is high and
// busy is low. req_operation selects enqueue or dequeue; value and priority
// are used on enqueue only. busy never rises: one command per clock cycle.
// Response channel: each command gives exactly one beat, marked by
// rsp_strobe, in the cycle right after the command was taken.
// The receiver cannot stall; every beat is presented once only.
// Entries sit in the cells ordered by priority, highest first, and by age
// among equal priorities. An enqueue inserts in place while the cells below
// it shift down one step; a dequeue takes cell 0 and every cell shifts up.
// Each cell talks only to its two neighbors, so the logic path of a command
// does not lengthen with QUEUE_DEPTH; the cell compare and mux set the cycle time.
// Status reports a dequeue while empty or an enqueue while full; such
// commands leave the queue untouched. rsp_top_* and rsp_entry_count give the
// state after the command.
// Reset (synchronous) empties the queue and drops any pending response.
module stable_priority_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_item_value,
   input  logic [7:0]         req_item_priority,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic [7:0]         rsp_removed_priority,
   output logic               rsp_top_valid,
   output logic signed [31:0] rsp_top_value,
   output logic [7:0]         rsp_top_priority,
   output logic [4:0]         rsp_entry_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type chain [QUEUE_DEPTH];
   logic      go    [QUEUE_DEPTH];
   cmd_type   cmd;

   logic          accept;
   logic          is_full;
   logic          is_empty;
   logic [CW-1:0] count_ff, count_in;
   logic          strobe_ff;
   logic [1:0]    status_ff, status_in;
   logic signed [31:0] rem_value_ff, rem_value_in;
   logic [7:0]    rem_prio_ff, rem_prio_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CW'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      cmd.push       = 1'b0;
      cmd.pop        = 1'b0;
      cmd.item.valid = 1'b1;
      cmd.item.value = req_item_value;
      cmd.item.prio  = req_item_priority;
      count_in       = count_ff;
      status_in      = STATUS_OK;
      rem_value_in   = '0;
      rem_prio_in    = '0;
      if (accept) begin
         if (req_operation == OP_DEQUEUE) begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               cmd.pop      = 1'b1;
               count_in     = count_ff - CW'(1);
               rem_value_in = chain[0].value;
               rem_prio_in  = chain[0].prio;
            end
         end else begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_g;
      if (i == 0) begin : g_first
         assign prev_e = cmd.item;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_e = chain[i-1];
         assign prev_g = go[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = chain[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .prev_go    (prev_g),
         .next_entry (next_e),
         .entry      (chain[i]),
         .go         (go[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
      status_ff    <= status_in;
      rem_value_ff <= rem_value_in;
      rem_prio_ff  <= rem_prio_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = rem_value_ff;
   assign rsp_removed_priority = rem_prio_ff;
   assign rsp_top_valid        = chain[0].valid;
   assign rsp_top_value        = chain[0].valid ? chain[0].value : '0;
   assign rsp_top_priority     = chain[0].valid ? chain[0].prio : '0;
   assign rsp_entry_count      = 5'(count_ff);

endmodule
